/* rtl/core/sidasc_pkg.sv */
package sidasc_pkg;

	// width of one packed BCD digit
	localparam int unsigned DIGIT_W = 4;

	// ASCII character width and the fixed codes used in the text
	localparam int unsigned CHAR_W = 7;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;

endpackage

/* rtl/core/sidasc_dabble.sv */
module sidasc_dabble #(
	parameter int unsigned VALUE_BITS = 32,
	parameter int unsigned NUM_DIGITS = 10
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [VALUE_BITS-1:0]                        value,
	input  logic                                         value_valid,
	output logic                                         value_ready,
	output logic [NUM_DIGITS*sidasc_pkg::DIGIT_W-1:0]    bcd,
	output logic                                         negative,
	output logic                                         conv_valid,
	input  logic                                         conv_ready
);

	localparam int unsigned BCD_W = NUM_DIGITS * sidasc_pkg::DIGIT_W;
	localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [VALUE_BITS-1:0]   mag_q;
	logic [BCD_W-1:0]        bcd_q;
	logic                    neg_q;
	logic [VALUE_BITS-1:0]   mag_in;
	logic [BCD_W-1:0]        bcd_adj;

	// magnitude as unsigned, so the most negative value wraps to 2^(N-1)
	assign mag_in = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

	// add-3 correction on every digit lane before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[i*sidasc_pkg::DIGIT_W +: sidasc_pkg::DIGIT_W] >= 4'd5)
				bcd_adj[i*sidasc_pkg::DIGIT_W +: sidasc_pkg::DIGIT_W] =
					bcd_q[i*sidasc_pkg::DIGIT_W +: sidasc_pkg::DIGIT_W] + 4'd3;
			else
				bcd_adj[i*sidasc_pkg::DIGIT_W +: sidasc_pkg::DIGIT_W] =
					bcd_q[i*sidasc_pkg::DIGIT_W +: sidasc_pkg::DIGIT_W];
		end
	end

	// sequencer: load, one bit per cycle, then hold until the emitter takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (value_valid) begin
						mag_q   <= mag_in;
						neg_q   <= value[VALUE_BITS-1];
						bcd_q   <= '0;
						cnt_q   <= CNT_W'(VALUE_BITS);
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
					mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (conv_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign value_ready = (state_q == ST_IDLE);
	assign conv_valid  = (state_q == ST_DONE);
	assign bcd         = bcd_q;
	assign negative    = neg_q;

endmodule

/* rtl/core/sidasc_emit.sv */
module sidasc_emit #(
	parameter int unsigned NUM_DIGITS = 10
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [NUM_DIGITS*sidasc_pkg::DIGIT_W-1:0]    bcd,
	input  logic                                         negative,
	input  logic                                         conv_valid,
	output logic                                         conv_ready,
	output logic [sidasc_pkg::CHAR_W-1:0]                character,
	output logic                                         last,
	output logic                                         char_valid,
	input  logic                                         char_ready
);

	localparam int unsigned BCD_W = NUM_DIGITS * sidasc_pkg::DIGIT_W;
	localparam int unsigned REM_W = $clog2(NUM_DIGITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SKIP,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	state_t                              state_q;
	logic [BCD_W-1:0]                    bcd_q;
	logic                                neg_q;
	logic [REM_W-1:0]                    rem_q;
	logic [sidasc_pkg::CHAR_W-1:0]       char_q;
	logic                                last_q;
	logic                                valid_q;
	logic [sidasc_pkg::DIGIT_W-1:0]      top_digit;
	logic                                slot_free;
	logic                                load_char;

	// digits leave from the top of the shift register, most significant first
	assign top_digit = bcd_q[BCD_W-1 -: sidasc_pkg::DIGIT_W];
	assign slot_free = !valid_q || char_ready;
	assign load_char = slot_free && (state_q == ST_SIGN || state_q == ST_DIGITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			rem_q   <= '0;
		end else begin
			// output register: refilled by the sequencer, drains on acceptance
			if (load_char)
				valid_q <= 1'b1;
			else if (char_ready)
				valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (conv_valid) begin
						bcd_q   <= bcd;
						neg_q   <= negative;
						rem_q   <= REM_W'(NUM_DIGITS);
						state_q <= ST_SKIP;
					end
				end
				// drop leading zeros, always keeping at least one digit
				ST_SKIP: begin
					if (top_digit == '0 && rem_q > REM_W'(1)) begin
						bcd_q <= {bcd_q[BCD_W-sidasc_pkg::DIGIT_W-1:0],
							{sidasc_pkg::DIGIT_W{1'b0}}};
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= neg_q ? ST_SIGN : ST_DIGITS;
					end
				end
				ST_SIGN: begin
					if (slot_free) begin
						char_q  <= sidasc_pkg::CHAR_MINUS;
						last_q  <= 1'b0;
						state_q <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (slot_free) begin
						char_q  <= sidasc_pkg::CHAR_ZERO + sidasc_pkg::CHAR_W'(top_digit);
						last_q  <= (rem_q == REM_W'(1));
						bcd_q   <= {bcd_q[BCD_W-sidasc_pkg::DIGIT_W-1:0],
							{sidasc_pkg::DIGIT_W{1'b0}}};
						rem_q   <= rem_q - 1'b1;
						if (rem_q == REM_W'(1))
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign conv_ready = (state_q == ST_IDLE);
	assign character  = char_q;
	assign last       = last_q;
	assign char_valid = valid_q;

endmodule

/* rtl/core/signed_int_to_decimal_ascii_top.sv */
// Signed integer to decimal ASCII text converter.
// Input channel: value (VALUE_BITS, two's complement) with value_valid and
// value_ready. Output channel: one ASCII character per item on character,
// with last marking the final character of a number, under char_valid and
// char_ready. A negative number starts with '-'; digits follow most
// significant first without leading zeros; zero gives a single '0'.
// Conversion is shift-and-add-3 binary to BCD, one input bit per cycle,
// on one bank of digit correction lanes. value_ready is high only while
// that unit is idle, so it takes a new item only after handing the last
// result to the emitter. The BCD result is handed to the character
// emitter, which skips leading zeros at one digit a cycle and then sends
// one character per cycle while the receiver accepts, overlapping the
// next conversion. The first character follows the loading, the shifting,
// the handover and the skipping of leading zeros.
// A stalled receiver holds the output register; the emitter then stops and
// the converter waits to hand over, after which value_ready stays low.
// Reset clears both sequencers and the output valid; no item is kept.
module signed_int_to_decimal_ascii_top #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [VALUE_BITS-1:0]            value,
	input  logic                             value_valid,
	output logic                             value_ready,
	output logic [sidasc_pkg::CHAR_W-1:0]    character,
	output logic                             last,
	output logic                             char_valid,
	input  logic                             char_ready
);

	// decimal digits of 2^(VALUE_BITS-1), the largest magnitude
	localparam int unsigned NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
	localparam int unsigned BCD_W      = NUM_DIGITS * sidasc_pkg::DIGIT_W;

	logic [BCD_W-1:0] bcd;
	logic             negative;
	logic             conv_valid;
	logic             conv_ready;

	sidasc_dabble #(
		.VALUE_BITS (VALUE_BITS),
		.NUM_DIGITS (NUM_DIGITS)
	) u_dabble (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.bcd         (bcd),
		.negative    (negative),
		.conv_valid  (conv_valid),
		.conv_ready  (conv_ready)
	);

	sidasc_emit #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.bcd        (bcd),
		.negative   (negative),
		.conv_valid (conv_valid),
		.conv_ready (conv_ready),
		.character  (character),
		.last       (last),
		.char_valid (char_valid),
		.char_ready (char_ready)
	);

`ifndef ASSERT_OFF
	// only a minus sign or a decimal digit ever leaves
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (character == sidasc_pkg::CHAR_MINUS ||
			(character >= sidasc_pkg::CHAR_ZERO && character <= sidasc_pkg::CHAR_NINE)))
		else $error("illegal output character");

	// the sign never closes a number
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && character == sidasc_pkg::CHAR_MINUS) |-> !last)
		else $error("minus sign flagged as last");

	// converter is busy right after taking an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(value_valid && value_ready) |=> !value_ready)
		else $error("converter ready straight after accept");

	// a finished conversion waits for the emitter and is not dropped
	a_handoff_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(conv_valid && !conv_ready) |=> (conv_valid && $stable(bcd) && $stable(negative)))
		else $error("conversion result lost before handoff");
`endif

endmodule
